// ----- rtl/cdq_pkg.sv -----
// Shared types and constants for the circular deque.
package cdq_pkg;

    localparam int WORD_W  = 32;
    localparam int CNT_W   = 5;
    localparam int CMD_W   = 3;
    localparam int CAP_RESET = 16;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam t_cmd CMD_INS_FRONT = 3'd0;
    localparam t_cmd CMD_INS_REAR  = 3'd1;
    localparam t_cmd CMD_DEL_FRONT = 3'd2;
    localparam t_cmd CMD_DEL_REAR  = 3'd3;
    localparam t_cmd CMD_PEEK      = 3'd4;

    localparam t_word EMPTY_WORD = '1;

    // Configuration register index (byte address 4 * index)
    localparam logic REG_CAPACITY = 1'b0;

endpackage

// ----- rtl/cdq_if.sv -----
// Valid/ready channel interfaces for deque commands and results.
interface cdq_cmd_if
    import cdq_pkg::*;
;
    logic  valid;
    logic  ready;
    t_cmd  command;
    t_word value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

interface cdq_res_if
    import cdq_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  ok;
    t_word front_value;
    t_word rear_value;
    logic  is_empty;
    logic  is_full;
    t_cnt  count;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, output count, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, input count, output ready);
endinterface

// ----- rtl/circular_deque.sv -----
// Double-ended ring buffer of signed 32-bit words held in one synchronous RAM.
//
// Channels: i_cmd carries a command (insert front/rear, delete front/rear,
// peek) and a word; o_res returns one result per command with the success
// flag, front and rear words after the step (all ones when empty), the empty
// and full flags and the entry count. The APB port holds one register,
// capacity, at byte address 0; writing it empties the deque.
//
// Timing: a command is taken in the idle state, where pointers and count are
// updated and an insert writes the RAM. The read state that follows reads the
// RAM at the new front and rear pointers on its two read ports; the load state
// then loads the output register once it is free. A new command is taken only
// after the previous one has left the load state.
//
// Reset leaves the deque empty with capacity min(16, DEPTH); RAM contents are
// not cleared. When the receiver stalls, a finished result waits in the
// output register while the next command is processed; that command's
// result waits in the load state until the register frees up.
module circular_deque
    import cdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdq_cmd_if.sink     i_cmd,
    cdq_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = (AW + 1 > CNT_W + 1) ? AW + 1 : CNT_W + 1;
    localparam t_cnt CAP_RST = (DEPTH < CAP_RESET) ? CNT_W'(DEPTH) : CNT_W'(CAP_RESET);
    localparam logic [AW-1:0] REAR_RST = AW'(int'(CAP_RST) - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    t_word mem [DEPTH];

    logic [1:0]    r_state, n_state;
    t_cnt          r_cap, n_cap;
    t_cnt          r_fill, n_fill;
    logic [AW-1:0] r_front_ptr, n_front_ptr;
    logic [AW-1:0] r_rear_ptr, n_rear_ptr;
    logic          r_ok, n_ok;
    t_word         r_rd_front, r_rd_rear;

    logic          r_out_valid;
    logic          r_out_ok;
    t_word         r_out_front, r_out_rear;
    logic          r_out_empty, r_out_full;
    t_cnt          r_out_count;

    logic          cmd_xfer, cfg_wr, out_load, is_full, is_empty;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [CW-1:0] cap_ext, cap_m1, front_inc, rear_inc, wr_ext;
    logic [AW-1:0] front_next, front_prev, rear_next, rear_prev;
    t_cnt          cap_wr;

    assign pready   = 1'b1;
    assign prdata   = {{(32-CNT_W){1'b0}}, r_cap};
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign out_load    = (r_state == ST_LOAD) && (!r_out_valid || o_res.ready);

    // Pointer wrap by compare against the capacity
    always_comb begin
        cap_ext    = {{(CW-CNT_W){1'b0}}, r_cap};
        cap_m1     = cap_ext - CW'(1);
        front_inc  = {{(CW-AW){1'b0}}, r_front_ptr} + CW'(1);
        rear_inc   = {{(CW-AW){1'b0}}, r_rear_ptr} + CW'(1);
        front_next = (front_inc >= cap_ext) ? '0 : front_inc[AW-1:0];
        rear_next  = (rear_inc >= cap_ext) ? '0 : rear_inc[AW-1:0];
        front_prev = (r_front_ptr == '0) ? cap_m1[AW-1:0] : r_front_ptr - AW'(1);
        rear_prev  = (r_rear_ptr == '0) ? cap_m1[AW-1:0] : r_rear_ptr - AW'(1);
        is_full    = (r_fill >= r_cap);
        is_empty   = (r_fill == '0);
    end

    // Capacity clamp: 0 reads as 1, above DEPTH saturates
    always_comb begin
        wr_ext = {{(CW-CNT_W){1'b0}}, pwdata[CNT_W-1:0]};
        priority if (pwdata[CNT_W-1:0] == '0) begin
            cap_wr = CNT_W'(1);
        end else if (wr_ext > CW'(DEPTH)) begin
            cap_wr = CNT_W'(DEPTH);
        end else begin
            cap_wr = pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cap       = r_cap;
        n_fill      = r_fill;
        n_front_ptr = r_front_ptr;
        n_rear_ptr  = r_rear_ptr;
        n_ok        = r_ok;
        mem_we      = 1'b0;
        mem_wa      = r_front_ptr;
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_xfer) begin
                    n_state = ST_READ;
                    n_ok    = 1'b0;
                    unique case (i_cmd.command)
                        CMD_INS_FRONT: begin
                            if (!is_full) begin
                                n_front_ptr = front_prev;
                                mem_wa      = front_prev;
                                mem_we      = 1'b1;
                                n_fill      = r_fill + CNT_W'(1);
                                n_ok        = 1'b1;
                            end
                        end
                        CMD_INS_REAR: begin
                            if (!is_full) begin
                                n_rear_ptr = rear_next;
                                mem_wa     = rear_next;
                                mem_we     = 1'b1;
                                n_fill     = r_fill + CNT_W'(1);
                                n_ok       = 1'b1;
                            end
                        end
                        CMD_DEL_FRONT: begin
                            if (!is_empty) begin
                                n_front_ptr = front_next;
                                n_fill      = r_fill - CNT_W'(1);
                                n_ok        = 1'b1;
                            end
                        end
                        CMD_DEL_REAR: begin
                            if (!is_empty) begin
                                n_rear_ptr = rear_prev;
                                n_fill     = r_fill - CNT_W'(1);
                                n_ok       = 1'b1;
                            end
                        end
                        CMD_PEEK: begin
                            n_ok = 1'b1;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // Register writes are to arrive only while idle; the block does not enforce this
        if (cfg_wr) begin
            n_cap       = cap_wr;
            n_fill      = '0;
            n_front_ptr = '0;
            n_rear_ptr  = AW'(cap_wr - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RST;
            r_fill      <= '0;
            r_front_ptr <= '0;
            r_rear_ptr  <= REAR_RST;
            r_ok        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_fill      <= n_fill;
            r_front_ptr <= n_front_ptr;
            r_rear_ptr  <= n_rear_ptr;
            r_ok        <= n_ok;
        end
    end

    // Entry RAM: write on transfer, both ends read in the read state that follows
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= i_cmd.value;
        end
        if (r_state == ST_READ) begin
            r_rd_front <= mem[r_front_ptr];
            r_rd_rear  <= mem[r_rear_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ok    <= r_ok;
            r_out_front <= is_empty ? EMPTY_WORD : r_rd_front;
            r_out_rear  <= is_empty ? EMPTY_WORD : r_rd_rear;
            r_out_empty <= is_empty;
            r_out_full  <= (r_fill == r_cap);
            r_out_count <= r_fill;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.ok          = r_out_ok;
    assign o_res.front_value = r_out_front;
    assign o_res.rear_value  = r_out_rear;
    assign o_res.is_empty    = r_out_empty;
    assign o_res.is_full     = r_out_full;
    assign o_res.count       = r_out_count;

    a_fill_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cap)
        else $error("fill count above capacity");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({{(CW-AW){1'b0}}, r_front_ptr} < cap_ext) && ({{(CW-AW){1'b0}}, r_rear_ptr} < cap_ext))
        else $error("pointer beyond capacity");

    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_xfer && mem_we) |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("insert did not bump the count");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_empty == (r_out_count == '0)))
        else $error("empty flag disagrees with count");

    a_load_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_xfer |=> (r_state == ST_READ) ##1 (r_state == ST_LOAD))
        else $error("command did not pass through the RAM read");

endmodule

// ----- tb/tb_circular_deque.sv -----
// Self-checking testbench for circular_deque: directed, backpressure and random traffic.
module tb_circular_deque;
    import cdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int SETTLE_CYC  = 6;    // wait after the last result, with margin
    localparam int LONG_HOLD   = 120;

    typedef struct packed {
        logic  ok;
        t_word front_value;
        t_word rear_value;
        logic  is_empty;
        logic  is_full;
        t_cnt  count;
    } t_deque_status;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cdq_cmd_if cmd_ch ();
    cdq_res_if res_ch ();

    circular_deque #(.DEPTH(DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the deque
    t_word      slot_mem [DEPTH];
    logic [3:0] front_idx;
    logic [3:0] rear_idx;
    t_cnt       fill_cnt;
    t_cnt       cap_reg;

    t_deque_status expected_status[$];
    int  err_cnt;
    bit  filling;

    // Receiver state
    int rx_tick;
    int hold_left;
    int holds_asked;
    int holds_done;
    int stall_left;

    always #10 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [3:0] wrap_next(input logic [3:0] p);
        return ({1'b0, p} + 5'd1 >= cap_reg) ? 4'd0 : p + 4'd1;
    endfunction

    function automatic logic [3:0] wrap_prev(input logic [3:0] p);
        return (p == 4'd0) ? 4'(cap_reg - 5'd1) : p - 4'd1;
    endfunction

    function automatic void clear_shadow();
        front_idx = 4'd0;
        rear_idx  = 4'(cap_reg - 5'd1);
        fill_cnt  = '0;
    endfunction

    function automatic t_deque_status apply_command(input t_cmd cmd, input t_word val);
        logic          full;
        t_deque_status r;
        full = (fill_cnt >= cap_reg);
        r.ok = 1'b0;
        case (cmd)
            CMD_INS_FRONT: if (!full) begin
                front_idx = wrap_prev(front_idx);
                slot_mem[front_idx] = val;
                fill_cnt = fill_cnt + 5'd1;
                r.ok = 1'b1;
            end
            CMD_INS_REAR: if (!full) begin
                rear_idx = wrap_next(rear_idx);
                slot_mem[rear_idx] = val;
                fill_cnt = fill_cnt + 5'd1;
                r.ok = 1'b1;
            end
            CMD_DEL_FRONT: if (fill_cnt != 0) begin
                front_idx = wrap_next(front_idx);
                fill_cnt = fill_cnt - 5'd1;
                r.ok = 1'b1;
            end
            CMD_DEL_REAR: if (fill_cnt != 0) begin
                rear_idx = wrap_prev(rear_idx);
                fill_cnt = fill_cnt - 5'd1;
                r.ok = 1'b1;
            end
            CMD_PEEK: r.ok = 1'b1;
            default: r.ok = 1'b0;
        endcase
        r.is_empty    = (fill_cnt == 0);
        r.front_value = r.is_empty ? EMPTY_WORD : slot_mem[front_idx];
        r.rear_value  = r.is_empty ? EMPTY_WORD : slot_mem[rear_idx];
        r.is_full     = (fill_cnt == cap_reg);
        r.count       = fill_cnt;
        return r;
    endfunction

    function automatic t_word pick_value();
        case ($urandom_range(0, 7))
            0: return t_word'(32'h8000_0000);
            1: return t_word'(32'h7fff_ffff);
            2: return EMPTY_WORD;
            3: return '0;
            4: return t_word'($urandom_range(0, 255));
            default: return t_word'($urandom());
        endcase
    endfunction

    // Mostly well-formed fill/drain runs, with peeks and unknown codes mixed in
    function automatic t_cmd pick_command();
        int r;
        bit grow;
        r = $urandom_range(0, 99);
        if (r < 3)
            return t_cmd'($urandom_range(5, 7));
        if (r < 10)
            return CMD_PEEK;
        grow = filling ? (r < 75) : (r < 35);
        if (grow)
            return $urandom_range(0, 1) ? CMD_INS_REAR : CMD_INS_FRONT;
        return $urandom_range(0, 1) ? CMD_DEL_REAR : CMD_DEL_FRONT;
    endfunction

    task automatic send_command(input t_cmd cmd, input t_word val);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.value   <= val;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        expected_status.insert(expected_status.size(), apply_command(cmd, val));
    endtask

    task automatic idle_cycles(input int n);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_CAPACITY) << 2;
        pwdata  <= {27'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (v == 5'd0)
            cap_reg = 5'd1;
        else if (v > 5'(DEPTH))
            cap_reg = 5'(DEPTH);
        else
            cap_reg = v;
        clear_shadow();
        @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_deque_status exp_r;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_status.size() == 0) begin
                $error("result transfer with no command outstanding");
                err_cnt++;
            end else begin
                exp_r = expected_status.pop_front();
                check_field("ok",          32'(exp_r.ok),       32'(res_ch.ok));
                check_field("front_value", exp_r.front_value,   res_ch.front_value);
                check_field("rear_value",  exp_r.rear_value,    res_ch.rear_value);
                check_field("is_empty",    32'(exp_r.is_empty), 32'(res_ch.is_empty));
                check_field("is_full",     32'(exp_r.is_full),  32'(res_ch.is_full));
                check_field("count",       32'(exp_r.count),    32'(res_ch.count));
            end
        end
    end

    // Receiver: rotating stall patterns plus an on-request long hold-off
    always @(posedge i_clk) begin
        rx_tick++;
        if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            case ((rx_tick / 300) % 4)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2: res_ch.ready <= (rx_tick % 5 != 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        res_ch.ready <= 1'b0;
                    end else begin
                        if ($urandom_range(0, 9) == 0)
                            stall_left = $urandom_range(2, 12);
                        res_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    task automatic test_empty_deque();
        send_command(CMD_PEEK, pick_value());
        send_command(CMD_DEL_FRONT, pick_value());
        send_command(CMD_DEL_REAR, pick_value());
        send_command(t_cmd'(5), pick_value());
        send_command(t_cmd'(6), pick_value());
        send_command(t_cmd'(7), pick_value());
        wait_idle();
    endtask

    // Front insert from index 0 wraps to the top slot
    task automatic test_word_extremes();
        send_command(CMD_INS_FRONT, t_word'(32'h8000_0000));
        send_command(CMD_INS_REAR, t_word'(32'h7fff_ffff));
        send_command(CMD_INS_FRONT, EMPTY_WORD);
        send_command(CMD_INS_REAR, '0);
        send_command(CMD_PEEK, t_word'(32'h5555_aaaa));
        send_command(CMD_DEL_FRONT, '0);
        send_command(CMD_DEL_REAR, '0);
        send_command(CMD_DEL_FRONT, '0);
        send_command(CMD_DEL_REAR, '0);
        send_command(t_cmd'(7), '0);
        wait_idle();
    endtask

    // Zero saturates to one entry, oversize saturates to DEPTH
    task automatic test_capacity_limits();
        write_capacity(5'd0);
        send_command(CMD_INS_REAR, t_word'(32'h1234_5678));
        send_command(CMD_INS_FRONT, t_word'(32'hdead_beef));
        send_command(CMD_INS_REAR, t_word'(32'hcafe_f00d));
        send_command(t_cmd'(5), '0);
        send_command(CMD_DEL_FRONT, '0);
        send_command(CMD_DEL_REAR, '0);
        wait_idle();
        write_capacity(5'd31);
    endtask

    task automatic test_backpressure();
        write_capacity(5'd16);
        holds_asked++;
        repeat (24) send_command(pick_command(), pick_value());
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [4:0] cap_val, input int n_items,
                                       input bit use_gaps);
        int burst_left;
        burst_left = 0;
        write_capacity(cap_val);
        filling = 1'b1;
        repeat (n_items) begin
            if (fill_cnt == cap_reg)
                filling = 1'b0;
            else if (fill_cnt == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                filling = !filling;
            if (use_gaps && burst_left == 0) begin
                idle_cycles($urandom_range(1, 10));
                burst_left = $urandom_range(1, 16);
            end
            send_command(pick_command(), pick_value());
            if (burst_left > 0)
                burst_left--;
        end
        wait_idle();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.command = CMD_PEEK;
        cmd_ch.value   = '0;
        res_ch.ready   = 1'b0;
        err_cnt        = 0;
        rx_tick        = 0;
        hold_left      = 0;
        holds_asked    = 0;
        holds_done     = 0;
        stall_left     = 0;
        filling        = 1'b1;
        foreach (slot_mem[i]) slot_mem[i] = '0;
        cap_reg = 5'(CAP_RESET);
        clear_shadow();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_deque();
        test_word_extremes();
        test_capacity_limits();
        test_backpressure();
        test_random_traffic(5'd16, 300, 1'b1);
        test_random_traffic(5'd1, 100, 1'b1);
        test_random_traffic(5'd2, 150, 1'b1);
        test_random_traffic(5'd3, 150, 1'b0);
        test_random_traffic(5'd0, 60, 1'b1);
        test_random_traffic(5'd31, 200, 1'b0);
        test_random_traffic(5'd5, 150, 1'b1);
        test_random_traffic(5'd17, 150, 1'b1);
        test_random_traffic(5'd8, 150, 1'b1);
        repeat (3) test_random_traffic(5'($urandom_range(0, 31)), 100, 1'b1);
        test_backpressure();

        wait_idle();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0 && expected_status.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
